@@ hw/rtl/pee_pkg.sv @@
// shared types, constants and decode helpers for the prefix expression evaluator
`timescale 1ns / 1ps

package pee_pkg;

	// default number of pending operators the stack can hold
	localparam int STACK_DEPTH = 64;

	// ascii codes of the operand base and the arithmetic operators
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_DIV_ZERO  = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} sym_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
	} res_t;

	// one stack entry: pending operator, left operand flag and left operand
	typedef struct packed {
		logic [7:0]  op;
		logic        present;
		logic [31:0] left;
	} stack_entry_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_ZERO
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
		logic        div_zero;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_ALU,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		ALU_ST_IDLE,
		ALU_ST_SHIFT,
		ALU_ST_FIX,
		ALU_ST_DONE
	} alu_state_t;

	// operand digits '0' to '9'
	function automatic logic is_digit(input logic [7:0] sym);
		is_digit = (sym >= SYM_ZERO) && (sym <= SYM_NINE);
	endfunction

	// map an operator symbol to the shared unit operation
	function automatic alu_op_t decode_op(input logic [7:0] sym);
		alu_op_t op;
		case (sym)
			SYM_PLUS:  op = ALU_ADD;
			SYM_MINUS: op = ALU_SUB;
			SYM_STAR:  op = ALU_MUL;
			SYM_SLASH: op = ALU_DIV;
			default:   op = ALU_ZERO;
		endcase
		decode_op = op;
	endfunction

endpackage

@@ hw/rtl/pee_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

@@ hw/rtl/pee_alu.sv @@
// shared arithmetic unit: add, subtract, multiply and bit-serial signed divide
`timescale 1ns / 1ps

module pee_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  pee_pkg::alu_req_t req,
	output pee_pkg::alu_rsp_t rsp
);

	pee_pkg::alu_state_t state_q, state_d;

	logic [31:0] result_q, result_d;
	logic        dz_q, dz_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] quo_q, quo_d;
	logic [31:0] dvs_q, dvs_d;
	logic        neg_q, neg_d;
	logic [4:0]  cnt_q, cnt_d;

	logic [32:0] partial;
	logic [33:0] diff;

	// one restoring step per cycle
	assign partial = {rem_q, quo_q[31]};
	assign diff    = {1'b0, partial} - {2'b00, dvs_q};

	// next state and datapath
	always_comb begin
		state_d  = state_q;
		result_d = result_q;
		dz_d     = dz_q;
		rem_d    = rem_q;
		quo_d    = quo_q;
		dvs_d    = dvs_q;
		neg_d    = neg_q;
		cnt_d    = cnt_q;
		unique case (state_q)
			pee_pkg::ALU_ST_IDLE: begin
				if (req.start) begin
					dz_d    = 1'b0;
					state_d = pee_pkg::ALU_ST_DONE;
					case (req.op)
						pee_pkg::ALU_ADD: result_d = req.a + req.b;
						pee_pkg::ALU_SUB: result_d = req.a - req.b;
						pee_pkg::ALU_MUL: result_d = req.a * req.b;
						pee_pkg::ALU_DIV: begin
							if (req.b == 32'd0) begin
								result_d = 32'd0;
								dz_d     = 1'b1;
							end else begin
								rem_d   = 32'd0;
								quo_d   = req.a[31] ? (32'd0 - req.a) : req.a;
								dvs_d   = req.b[31] ? (32'd0 - req.b) : req.b;
								neg_d   = req.a[31] ^ req.b[31];
								cnt_d   = 5'd0;
								state_d = pee_pkg::ALU_ST_SHIFT;
							end
						end
						default: result_d = 32'd0;
					endcase
				end
			end
			pee_pkg::ALU_ST_SHIFT: begin
				if (!diff[33]) begin
					rem_d = diff[31:0];
					quo_d = {quo_q[30:0], 1'b1};
				end else begin
					rem_d = partial[31:0];
					quo_d = {quo_q[30:0], 1'b0};
				end
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = pee_pkg::ALU_ST_FIX;
				end
			end
			pee_pkg::ALU_ST_FIX: begin
				result_d = neg_q ? (32'd0 - quo_q) : quo_q;
				state_d  = pee_pkg::ALU_ST_DONE;
			end
			pee_pkg::ALU_ST_DONE: begin
				state_d = pee_pkg::ALU_ST_IDLE;
			end
			default: state_d = pee_pkg::ALU_ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pee_pkg::ALU_ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		result_q <= result_d;
		dz_q     <= dz_d;
		rem_q    <= rem_d;
		quo_q    <= quo_d;
		dvs_q    <= dvs_d;
		neg_q    <= neg_d;
		cnt_q    <= cnt_d;
	end

	assign rsp.done     = (state_q == pee_pkg::ALU_ST_DONE);
	assign rsp.value    = result_q;
	assign rsp.div_zero = dz_q;

endmodule

@@ hw/rtl/prefix_expression_evaluator.sv @@
// top level: sequencer and operator stack of the prefix expression evaluator
`timescale 1ns / 1ps

// Evaluates a prefix expression fed one ASCII symbol per request, the last
// symbol flagged; one result (value and status) follows the flagged request.
// Pending operators and their left operands live in a ram of STACK_DEPTH
// entries; one shared arithmetic unit does every reduction. An operator is
// pushed; a digit reduces with each pending operator that already holds a
// left operand, then completes the expression or waits as the left operand
// of the next one. The divider produces one quotient bit per cycle. A new
// request is accepted while the previous result still waits to be taken.
// No clearing pass is needed after reset.
module prefix_expression_evaluator #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  pee_pkg::sym_req_t sym,
	output logic              res_valid,
	input  logic              res_ready,
	output pee_pkg::res_t     res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int EW = $bits(pee_pkg::stack_entry_t);

	pee_pkg::ctrl_state_t state_q, state_d;

	logic [LW-1:0]    level_q, level_d;
	logic             done_q, done_d;
	pee_pkg::status_t err_q, err_d;
	logic             last_q, last_d;
	logic             res_valid_q, res_valid_d;
	logic [31:0]      final_q, final_d;
	logic [31:0]      v_q, v_d;
	pee_pkg::res_t    res_q, res_d;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	pee_pkg::stack_entry_t ram_wentry;
	logic [EW-1:0]         ram_rdata;
	logic [AW-1:0]         top_addr;
	logic [LW-1:0]         level_m1;
	pee_pkg::stack_entry_t top_entry;

	pee_pkg::alu_req_t alu_req;
	pee_pkg::alu_rsp_t alu_rsp;

	// address of the top pending operator
	assign level_m1  = level_q - LW'(1);
	assign top_addr  = level_m1[AW-1:0];
	assign top_entry = pee_pkg::stack_entry_t'(ram_rdata);

	pee_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (EW'(ram_wentry)),
		.raddr  (top_addr),
		.rdata_q(ram_rdata)
	);

	pee_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.rsp   (alu_rsp)
	);

	assign sym_ready = (state_q == pee_pkg::ST_IDLE);

	// sequencer: next state, stack access and reductions
	always_comb begin
		state_d     = state_q;
		level_d     = level_q;
		done_d      = done_q;
		err_d       = err_q;
		last_d      = last_q;
		final_d     = final_q;
		v_d         = v_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		ram_we      = 1'b0;
		ram_waddr   = top_addr;
		ram_wentry  = '{op: top_entry.op, present: 1'b1, left: v_q};
		alu_req     = '{start: 1'b0, op: pee_pkg::decode_op(top_entry.op),
			a: top_entry.left, b: v_q};
		unique case (state_q)
			pee_pkg::ST_IDLE: begin
				if (sym_valid) begin
					last_d  = sym.last_symbol;
					state_d = pee_pkg::ST_FINISH;
					if (!done_q) begin
						if (pee_pkg::is_digit(sym.symbol)) begin
							// digit value is the low nibble of its code
							v_d     = {28'd0, sym.symbol[3:0]};
							state_d = pee_pkg::ST_SCAN;
						end else if (level_q >= LW'(STACK_DEPTH)) begin
							err_d  = pee_pkg::STATUS_MALFORMED;
							done_d = 1'b1;
						end else begin
							ram_we     = 1'b1;
							ram_waddr  = level_q[AW-1:0];
							ram_wentry = '{op: sym.symbol, present: 1'b0, left: 32'd0};
							level_d    = level_q + LW'(1);
						end
					end
				end
			end
			pee_pkg::ST_SCAN: begin
				if (level_q == '0) begin
					final_d = v_q;
					done_d  = 1'b1;
					state_d = pee_pkg::ST_FINISH;
				end else begin
					state_d = pee_pkg::ST_CHECK;
				end
			end
			pee_pkg::ST_CHECK: begin
				if (!top_entry.present) begin
					// store the left operand and wait for the right one
					ram_we  = 1'b1;
					state_d = pee_pkg::ST_FINISH;
				end else begin
					alu_req.start = 1'b1;
					state_d       = pee_pkg::ST_ALU;
				end
			end
			pee_pkg::ST_ALU: begin
				if (alu_rsp.done) begin
					v_d     = alu_rsp.value;
					level_d = level_m1;
					if (alu_rsp.div_zero && (err_q == pee_pkg::STATUS_OK)) begin
						err_d = pee_pkg::STATUS_DIV_ZERO;
					end
					state_d = pee_pkg::ST_SCAN;
				end
			end
			pee_pkg::ST_FINISH: begin
				if (!last_q) begin
					state_d = pee_pkg::ST_IDLE;
				end else if (!res_valid_q || res_ready) begin
					if (!done_q) begin
						res_d = '{value: 32'sd0, status: pee_pkg::STATUS_MALFORMED};
					end else if (err_q != pee_pkg::STATUS_OK) begin
						res_d = '{value: 32'sd0, status: err_q};
					end else begin
						res_d = '{value: $signed(final_q), status: pee_pkg::STATUS_OK};
					end
					res_valid_d = 1'b1;
					// clear for the next expression
					level_d = '0;
					done_d  = 1'b0;
					err_d   = pee_pkg::STATUS_OK;
					final_d = 32'd0;
					state_d = pee_pkg::ST_IDLE;
				end
			end
			default: state_d = pee_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pee_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			done_q      <= 1'b0;
			err_q       <= pee_pkg::STATUS_OK;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
			final_q     <= 32'd0;
		end else begin
			level_q     <= level_d;
			done_q      <= done_d;
			err_q       <= err_d;
			last_q      <= last_d;
			res_valid_q <= res_valid_d;
			final_q     <= final_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		v_q   <= v_d;
		res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
